/* hw/rtl/kcl_pkg.sv */
// kcl_pkg: shared types, codes and the key decode table of the keypad code lock
// depends on nothing; used by every rtl file of the block
`default_nettype none

package kcl_pkg;

   localparam int CODE_DIGITS_DEF = 8;
   localparam int CMDQ_DEPTH = 2;

   localparam int KEY_W = 5;
   localparam int EVENT_W = 3;
   localparam int COUNT_OUT_W = 4;
   localparam int MODE_W = 2;
   localparam int PACK_W = 32;

   // raw key codes with a function of their own
   localparam logic [3:0] KEY_BACKSPACE = 4'd8;
   localparam logic [3:0] KEY_CHANGE = 4'd12;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_DIGIT,
      CMD_BACKSPACE,
      CMD_CHANGE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0] digit;
   } cmd_type;

   typedef enum logic [2:0] {
      EV_NONE = 3'd0,
      EV_UNLOCK = 3'd1,
      EV_WRONG = 3'd2,
      EV_OLD_OK = 3'd3,
      EV_OLD_BAD = 3'd4,
      EV_SAVED = 3'd5
   } event_type;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_VERIFY = 2'd1,
      MODE_NEW = 2'd2
   } mode_type;

   // keypad map: column-wise digit layout of the pad
   function automatic cmd_type decode_key(input logic [KEY_W-1:0] key);
      cmd_type c;
      c.kind = CMD_NONE;
      c.digit = 4'd0;
      if (!key[KEY_W-1]) begin
         unique case (key[3:0])
            4'd4: begin c.kind = CMD_DIGIT; c.digit = 4'd0; end
            4'd5: begin c.kind = CMD_DIGIT; c.digit = 4'd7; end
            4'd6: begin c.kind = CMD_DIGIT; c.digit = 4'd4; end
            4'd7: begin c.kind = CMD_DIGIT; c.digit = 4'd1; end
            4'd9: begin c.kind = CMD_DIGIT; c.digit = 4'd8; end
            4'd10: begin c.kind = CMD_DIGIT; c.digit = 4'd5; end
            4'd11: begin c.kind = CMD_DIGIT; c.digit = 4'd2; end
            4'd13: begin c.kind = CMD_DIGIT; c.digit = 4'd9; end
            4'd14: begin c.kind = CMD_DIGIT; c.digit = 4'd6; end
            4'd15: begin c.kind = CMD_DIGIT; c.digit = 4'd3; end
            KEY_BACKSPACE: begin c.kind = CMD_BACKSPACE; end
            KEY_CHANGE: begin c.kind = CMD_CHANGE; end
            default: begin c.kind = CMD_NONE; end
         endcase
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/keypad_code_lock_top.sv */
// keypad_code_lock_top: one key code per beat in, one result beat out per key
// a taken key is written into the command queue, then executed into the result register once that is free
// throughput: one key per cycle sustained while results are popped; the execute stage takes one command a cycle
// full rises only when the command queue holds two commands behind an untaken result
// reset (synchronous, active high): entry empty, normal mode, password 1..8, no result waiting
// depends on kcl_pkg, kcl_front, kcl_cmd_queue, kcl_back
`default_nettype none

module keypad_code_lock_top
   import kcl_pkg::*;
#(
   parameter int CODE_DIGITS = CODE_DIGITS_DEF
)(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // key beats
   input  wire logic                   push,
   output logic                        full,
   input  wire logic [KEY_W-1:0]       req_key_code,
   // result beats
   output logic                        empty,
   input  wire logic                   pop,
   output logic [EVENT_W-1:0]          rsp_event_res,
   output logic [COUNT_OUT_W-1:0]      rsp_digits_entered,
   output logic [MODE_W-1:0]           rsp_lock_mode,
   output logic [PACK_W-1:0]           rsp_entry_digits,
   output logic [PACK_W-1:0]           rsp_saved_code
);

   cmd_type front_cmd;
   cmd_type q_cmd;
   logic q_valid;
   logic q_take;
   logic key_accept;

   // a beat is taken whenever the queue has room
   assign key_accept = push && !full;

   // front: key code to command, every code gives a command
   kcl_front u_front (
      .key_code (req_key_code),
      .cmd      (front_cmd)
   );

   // queue lets the key side keep flowing while a result waits for pop
   kcl_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (key_accept),
      .wr_cmd   (front_cmd),
      .full     (full),
      .rd_en    (q_take),
      .rd_valid (q_valid),
      .rd_cmd   (q_cmd)
   );

   // back: lock state and the result register
   kcl_back #(
      .CODE_DIGITS (CODE_DIGITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (q_valid),
      .cmd            (q_cmd),
      .cmd_take       (q_take),
      .empty          (empty),
      .pop            (pop),
      .event_res      (rsp_event_res),
      .digits_entered (rsp_digits_entered),
      .lock_mode      (rsp_lock_mode),
      .entry_digits   (rsp_entry_digits),
      .saved_code     (rsp_saved_code)
   );

endmodule

`default_nettype wire

/* hw/rtl/kcl_front.sv */
// kcl_front: classifies a raw key code into a lock command
// depends on kcl_pkg
`default_nettype none

module kcl_front
   import kcl_pkg::*;
(
   input  wire logic [KEY_W-1:0] key_code,
   output cmd_type               cmd
);

   // unmapped codes still become a command so that they produce a beat
   always_comb begin
      cmd = decode_key(key_code);
   end

endmodule

`default_nettype wire

/* hw/rtl/kcl_cmd_queue.sv */
// kcl_cmd_queue: short command queue between the decode and execute parts
// depends on kcl_pkg
`default_nettype none

module kcl_cmd_queue
   import kcl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_en,
   input  cmd_type      wr_cmd,
   output logic         full,
   input  wire logic    rd_en,
   output logic         rd_valid,
   output cmd_type      rd_cmd
);

   localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type mem_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(CMDQ_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   assign full = (count_ff == CNT_W'(CMDQ_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_en ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = rd_en ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/kcl_back.sv */
// kcl_back: entry, mode and password state; executes one command a cycle into a result
// register while that register is free or being popped; depends on kcl_pkg
`default_nettype none

module kcl_back
   import kcl_pkg::*;
#(
   parameter int CODE_DIGITS = CODE_DIGITS_DEF
)(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   cmd_valid,
   input  cmd_type                     cmd,
   output logic                        cmd_take,
   output logic                        empty,
   input  wire logic                   pop,
   output logic [EVENT_W-1:0]          event_res,
   output logic [COUNT_OUT_W-1:0]      digits_entered,
   output logic [MODE_W-1:0]           lock_mode,
   output logic [PACK_W-1:0]           entry_digits,
   output logic [PACK_W-1:0]           saved_code
);

   localparam int CNT_W = $clog2(CODE_DIGITS + 1);
   localparam int IDX_W = $clog2(CODE_DIGITS);
   localparam int BCD_W = 4 * CODE_DIGITS;

   // digit k sits at element CODE_DIGITS-1-k, so the packed vector is the bcd view
   logic [CODE_DIGITS-1:0][3:0] entry_ff, entry_in;
   logic [CODE_DIGITS-1:0][3:0] pw_ff, pw_in;
   logic [CODE_DIGITS-1:0][3:0] pw_reset;
   logic [CNT_W-1:0] count_ff, count_in;
   mode_type mode_ff, mode_in;

   logic out_valid_ff;
   event_type ev_ff, ev_in;
   logic [COUNT_OUT_W-1:0] cnt_out_ff, cnt_out_in;
   mode_type mode_out_ff;
   logic [PACK_W-1:0] entry_out_ff, entry_out_in;
   logic [PACK_W-1:0] saved_out_ff, saved_out_in;

   logic [IDX_W-1:0] wr_idx, bs_idx;
   logic [CNT_W-1:0] cnt_dec;
   logic [CNT_W+COUNT_OUT_W-1:0] cnt_ext;
   logic [BCD_W+PACK_W-1:0] entry_ext, saved_ext;
   logic match;

   for (genvar k = 0; k < CODE_DIGITS; k++) begin : g_pw_reset
      assign pw_reset[CODE_DIGITS-1-k] = 4'((k + 1) % 10);
   end

   assign cmd_take = cmd_valid && (!out_valid_ff || pop);
   assign empty = !out_valid_ff;

   assign cnt_dec = count_ff - CNT_W'(1);
   assign wr_idx = IDX_W'(CODE_DIGITS - 1) - count_ff[IDX_W-1:0];
   assign bs_idx = IDX_W'(CODE_DIGITS - 1) - cnt_dec[IDX_W-1:0];

   always_comb begin
      entry_in = entry_ff;
      count_in = count_ff;
      mode_in = mode_ff;
      pw_in = pw_ff;
      ev_in = EV_NONE;
      saved_out_in = '0;
      unique case (cmd.kind)
         CMD_DIGIT: begin
            if (count_ff < CNT_W'(CODE_DIGITS)) begin
               entry_in[wr_idx] = cmd.digit;
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_BACKSPACE: begin
            if (count_ff != '0) begin
               entry_in[bs_idx] = 4'd0;
               count_in = cnt_dec;
            end
         end
         CMD_CHANGE: begin
            mode_in = MODE_VERIFY;
            entry_in = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase

      match = (entry_in == pw_ff);
      saved_ext = '0;
      // full entry: act by mode, then clear
      if (count_in == CNT_W'(CODE_DIGITS)) begin
         unique case (mode_ff)
            MODE_NORMAL: begin
               ev_in = match ? EV_UNLOCK : EV_WRONG;
            end
            MODE_VERIFY: begin
               ev_in = match ? EV_OLD_OK : EV_OLD_BAD;
               mode_in = match ? MODE_NEW : MODE_NORMAL;
            end
            MODE_NEW: begin
               pw_in = entry_in;
               saved_ext = {{PACK_W{1'b0}}, entry_in};
               ev_in = EV_SAVED;
               mode_in = MODE_NORMAL;
            end
            default: begin
               mode_in = MODE_NORMAL;
            end
         endcase
         entry_in = '0;
         count_in = '0;
      end

      saved_out_in = saved_ext[PACK_W-1:0];
      entry_ext = {{PACK_W{1'b0}}, entry_in};
      entry_out_in = entry_ext[PACK_W-1:0];
      cnt_ext = {{COUNT_OUT_W{1'b0}}, count_in};
      cnt_out_in = cnt_ext[COUNT_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         count_ff <= '0;
         mode_ff <= MODE_NORMAL;
         pw_ff <= pw_reset;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd_take) begin
            entry_ff <= entry_in;
            count_ff <= count_in;
            mode_ff <= mode_in;
            pw_ff <= pw_in;
            out_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (cmd_take) begin
         ev_ff <= ev_in;
         cnt_out_ff <= cnt_out_in;
         mode_out_ff <= mode_in;
         entry_out_ff <= entry_out_in;
         saved_out_ff <= saved_out_in;
      end
   end

   assign event_res = ev_ff;
   assign digits_entered = cnt_out_ff;
   assign lock_mode = mode_out_ff;
   assign entry_digits = entry_out_ff;
   assign saved_code = saved_out_ff;

endmodule

`default_nettype wire

/* hw/rtl/kcl_checker.sv */
// kcl_checker: port-level checks of the keypad code lock, bound to the top level
// depends on kcl_pkg and keypad_code_lock_top
`default_nettype none

module kcl_checker
   import kcl_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   push,
   input wire logic                   full,
   input wire logic [KEY_W-1:0]       req_key_code,
   input wire logic                   empty,
   input wire logic                   pop,
   input wire logic [EVENT_W-1:0]     rsp_event_res,
   input wire logic [COUNT_OUT_W-1:0] rsp_digits_entered,
   input wire logic [MODE_W-1:0]      rsp_lock_mode,
   input wire logic [PACK_W-1:0]      rsp_entry_digits,
   input wire logic [PACK_W-1:0]      rsp_saved_code
);

   // an accepted key beat carries a known code
   a_key: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |-> !$isunknown(req_key_code))
      else $error("unknown key code accepted");

   // a stalled result beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_event_res) && $stable(rsp_entry_digits)))
      else $error("result beat changed while stalled");

   // saved code only carries data with a save event
   a_saved: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_event_res != EV_SAVED) |-> (rsp_saved_code == '0))
      else $error("saved code set without save event");

   // any reported event clears the entry
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_event_res != EV_NONE) |->
         (rsp_digits_entered == '0 && rsp_entry_digits == '0))
      else $error("entry not cleared after an event");

   // accepted old code leads to new-code mode, others to normal
   a_mode: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_event_res != EV_NONE) |->
         ((rsp_event_res == EV_OLD_OK) ? (rsp_lock_mode == MODE_NEW)
                                       : (rsp_lock_mode == MODE_NORMAL)))
      else $error("wrong mode after event");

endmodule

bind keypad_code_lock_top kcl_checker u_kcl_checker (
   .clock              (clock),
   .reset              (reset),
   .push               (push),
   .full               (full),
   .req_key_code       (req_key_code),
   .empty              (empty),
   .pop                (pop),
   .rsp_event_res      (rsp_event_res),
   .rsp_digits_entered (rsp_digits_entered),
   .rsp_lock_mode      (rsp_lock_mode),
   .rsp_entry_digits   (rsp_entry_digits),
   .rsp_saved_code     (rsp_saved_code)
);

`default_nettype wire

/* test/lock_scoreboard_pkg.sv */
// lock_scoreboard_pkg: key-by-key predictor of the code lock and the store of expected result beats
// depends on kcl_pkg for the event and mode codes and the port widths
package lock_scoreboard_pkg;
   import kcl_pkg::*;

   localparam int NDIG = CODE_DIGITS_DEF;
   localparam logic [3:0] NO_DIGIT = 4'hf;

   typedef struct {
      event_type ev;
      logic [COUNT_OUT_W-1:0] count;
      mode_type mode;
      logic [PACK_W-1:0] entry;
      logic [PACK_W-1:0] saved;
   } lock_result_type;

   // keypad layout, column by column
   function automatic logic [3:0] digit_of_key(input logic [KEY_W-1:0] key);
      if (key[KEY_W-1]) return NO_DIGIT;
      case (key[3:0])
         4'd4: return 4'd0;
         4'd5: return 4'd7;
         4'd6: return 4'd4;
         4'd7: return 4'd1;
         4'd9: return 4'd8;
         4'd10: return 4'd5;
         4'd11: return 4'd2;
         4'd13: return 4'd9;
         4'd14: return 4'd6;
         4'd15: return 4'd3;
         default: return NO_DIGIT;
      endcase
   endfunction

   class lock_scoreboard;
      logic [3:0] entry [NDIG];
      int unsigned count;
      mode_type mode;
      logic [3:0] password [NDIG];
      lock_result_type expected_results [$];
      int unsigned mismatches;
      int unsigned results_checked;
      int unsigned events_seen [6];

      function new();
         for (int k = 0; k < NDIG; k++) begin
            entry[k] = 4'd0;
            password[k] = 4'((k + 1) % 10);
         end
         count = 0;
         mode = MODE_NORMAL;
         mismatches = 0;
         results_checked = 0;
         foreach (events_seen[i]) events_seen[i] = 0;
      endfunction

      function logic [PACK_W-1:0] pack_digits(logic [3:0] d [NDIG]);
         logic [PACK_W-1:0] v;
         v = '0;
         for (int k = 0; k < NDIG; k++) v[4*(NDIG-1-k) +: 4] = d[k];
         return v;
      endfunction

      function logic [PACK_W-1:0] password_code();
         return pack_digits(password);
      endfunction

      // advance the lock by one accepted key and queue the beat it must produce
      function void note_key(logic [KEY_W-1:0] key);
         lock_result_type r;
         logic [3:0] d;
         bit ok;
         r.ev = EV_NONE;
         r.saved = '0;
         d = digit_of_key(key);
         if (d != NO_DIGIT) begin
            if (count < NDIG) begin
               entry[count] = d;
               count++;
            end
         end else if (key == {1'b0, KEY_BACKSPACE}) begin
            if (count > 0) begin
               count--;
               entry[count] = 4'd0;
            end
         end else if (key == {1'b0, KEY_CHANGE}) begin
            mode = MODE_VERIFY;
            foreach (entry[k]) entry[k] = 4'd0;
            count = 0;
         end
         if (count >= NDIG) begin
            ok = (pack_digits(entry) == pack_digits(password));
            case (mode)
               MODE_NORMAL: r.ev = ok ? EV_UNLOCK : EV_WRONG;
               MODE_VERIFY: begin
                  r.ev = ok ? EV_OLD_OK : EV_OLD_BAD;
                  mode = ok ? MODE_NEW : MODE_NORMAL;
               end
               MODE_NEW: begin
                  password = entry;
                  r.saved = pack_digits(password);
                  r.ev = EV_SAVED;
                  mode = MODE_NORMAL;
               end
               default: mode = MODE_NORMAL;
            endcase
            foreach (entry[k]) entry[k] = 4'd0;
            count = 0;
         end
         r.count = COUNT_OUT_W'(count);
         r.mode = mode;
         r.entry = pack_digits(entry);
         expected_results.push_back(r);
      endfunction

      task report_mismatch(string what, logic [PACK_W-1:0] got, logic [PACK_W-1:0] want);
         mismatches++;
         $display("mismatch on %s at result beat %0d: got %h, want %h",
                  what, results_checked, got, want);
      endtask

      task check_result(logic [EVENT_W-1:0] ev, logic [COUNT_OUT_W-1:0] cnt,
                        logic [MODE_W-1:0] md, logic [PACK_W-1:0] ent,
                        logic [PACK_W-1:0] sav);
         lock_result_type want;
         if (expected_results.size() == 0) begin
            report_mismatch("result beat with none expected", PACK_W'(ev), '0);
            return;
         end
         want = expected_results.pop_front();
         if (ev !== want.ev)
            report_mismatch("event_res", PACK_W'(ev), PACK_W'(want.ev));
         if (cnt !== want.count)
            report_mismatch("digits_entered", PACK_W'(cnt), PACK_W'(want.count));
         if (md !== want.mode)
            report_mismatch("lock_mode", PACK_W'(md), PACK_W'(want.mode));
         if (ent !== want.entry) report_mismatch("entry_digits", ent, want.entry);
         if (sav !== want.saved) report_mismatch("saved_code", sav, want.saved);
         events_seen[int'(want.ev)]++;
         results_checked++;
      endtask
   endclass

endpackage

/* test/keypad_code_lock_top_tb.sv */
// keypad_code_lock_top_tb: drives key beats into the code lock and checks every result beat
// depends on kcl_pkg, lock_scoreboard_pkg and the keypad_code_lock_top rtl
module keypad_code_lock_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import kcl_pkg::*;
   import lock_scoreboard_pkg::*;

   localparam int unsigned LIMIT = 400000;
   localparam int unsigned RANDOM_KEYS = 950;
   localparam int unsigned HOLD_CYCLES = 60;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam logic [KEY_W-1:0] KEY_BSP = {1'b0, KEY_BACKSPACE};
   localparam logic [KEY_W-1:0] KEY_CHG = {1'b0, KEY_CHANGE};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic [KEY_W-1:0] req_key_code = '0;
   logic full;
   logic empty;
   logic [EVENT_W-1:0] rsp_event_res;
   logic [COUNT_OUT_W-1:0] rsp_digits_entered;
   logic [MODE_W-1:0] rsp_lock_mode;
   logic [PACK_W-1:0] rsp_entry_digits;
   logic [PACK_W-1:0] rsp_saved_code;

   // idling odds in percent, changed per phase by the main process
   int unsigned sender_idle_pct = 12;
   int unsigned receiver_idle_pct = 69;
   int unsigned cycle_count = 0;
   int unsigned keys_sent = 0;
   int unsigned stall_cycles = 0;
   int unsigned hold_left = 0;
   bit hold_request = 1'b0;
   bit hold_done = 1'b0;

   lock_scoreboard sb = new();

   keypad_code_lock_top i_dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_key_code(req_key_code),
      .empty(empty),
      .pop(pop),
      .rsp_event_res(rsp_event_res),
      .rsp_digits_entered(rsp_digits_entered),
      .rsp_lock_mode(rsp_lock_mode),
      .rsp_entry_digits(rsp_entry_digits),
      .rsp_saved_code(rsp_saved_code)
   );

   always #5 clock = ~clock;

   // cycle count for the watchdog, and a tally of edges where the input was held back
   always @(posedge clock) begin
      cycle_count++;
      if (push && full) stall_cycles++;
   end

   initial begin
      wait (cycle_count >= LIMIT);
      $display("timeout after %0d cycles, %0d result beats still awaited",
               cycle_count, sb.expected_results.size());
      $display("== FAIL ==");
      $finish;
   end

   // receiver: pop decided at the falling edge; a long hold-off is counted down here
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_request && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // result beats are taken at the rising edge, values as they stood before it
   always @(posedge clock) begin
      if (!reset && pop === 1'b1 && empty === 1'b0)
         sb.check_result(rsp_event_res, rsp_digits_entered, rsp_lock_mode,
                         rsp_entry_digits, rsp_saved_code);
   end

   function automatic logic [KEY_W-1:0] key_for_digit(input logic [3:0] digit);
      case (digit)
         4'd0: return 5'd4;
         4'd1: return 5'd7;
         4'd2: return 5'd11;
         4'd3: return 5'd15;
         4'd4: return 5'd6;
         4'd5: return 5'd10;
         4'd6: return 5'd14;
         4'd7: return 5'd5;
         4'd8: return 5'd9;
         default: return 5'd13;
      endcase
   endfunction

   // one digit of the code swapped for a different one
   function automatic logic [PACK_W-1:0] corrupt_code(input logic [PACK_W-1:0] code);
      int unsigned k;
      logic [3:0] d;
      k = $urandom_range(0, NDIG - 1);
      d = code[4*k +: 4];
      code[4*k +: 4] = 4'((d + $urandom_range(1, 9)) % 10);
      return code;
   endfunction

   function automatic logic [PACK_W-1:0] random_code();
      logic [PACK_W-1:0] code;
      for (int k = 0; k < NDIG; k++) code[4*k +: 4] = 4'($urandom_range(0, 9));
      return code;
   endfunction

   // one key beat: called and left at a falling edge, returns once the key is taken
   task automatic send_key(input logic [KEY_W-1:0] key);
      int unsigned gap;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         push <= 1'b0;
         gap = $urandom_range(1, 3);
         repeat (gap) @(negedge clock);
      end
      push <= 1'b1;
      req_key_code <= key;
      do @(posedge clock); while (full);
      sb.note_key(key);
      keys_sent++;
      @(negedge clock);
   endtask

   // a full code, first digit first; with slip set a stray digit is typed and rubbed out
   // before one of the first seven digits, so the stray never completes the entry
   task automatic send_code(input logic [PACK_W-1:0] code, input bit slip);
      int unsigned slip_at;
      slip_at = $urandom_range(0, NDIG - 2);
      for (int k = 0; k < NDIG; k++) begin
         if (slip && k == slip_at) begin
            send_key(key_for_digit(4'($urandom_range(0, 9))));
            send_key(KEY_BSP);
         end
         send_key(key_for_digit(code[4*(NDIG-1-k) +: 4]));
      end
   endtask

   // one user session picked at random: mostly complete codes, some noise
   task automatic run_sequence();
      int unsigned pick;
      int unsigned n;
      logic [PACK_W-1:0] code;
      pick = $urandom_range(0, 99);
      // rub out whatever noise left in the entry so the codes line up
      n = sb.count;
      repeat (n) send_key(KEY_BSP);
      code = sb.password_code();
      if (pick < 35) begin
         // unlock attempt, right or wrong code
         if ($urandom_range(0, 1)) code = corrupt_code(code);
         send_code(code, $urandom_range(0, 4) == 0);
      end else if (pick < 60) begin
         // password change: old code, then a new one
         send_key(KEY_CHG);
         if ($urandom_range(0, 3) == 0) code = corrupt_code(code);
         send_code(code, $urandom_range(0, 4) == 0);
         send_code(random_code(), $urandom_range(0, 4) == 0);
      end else if (pick < 70) begin
         // part of a code, then abandoned
         n = $urandom_range(1, NDIG - 1);
         repeat (n) send_key(key_for_digit(4'($urandom_range(0, 9))));
         send_key($urandom_range(0, 1) ? KEY_CHG : KEY_BSP);
      end else if (pick < 78) begin
         // change key pressed again while the new code is half typed
         send_key(KEY_CHG);
         send_code(code, 1'b0);
         n = $urandom_range(1, NDIG - 1);
         repeat (n) send_key(key_for_digit(4'($urandom_range(0, 9))));
         send_key(KEY_CHG);
      end else begin
         // any raw code, unmapped ones and backspace on empty among them
         n = $urandom_range(1, 4);
         repeat (n) send_key(KEY_W'($urandom_range(0, 31)));
      end
   endtask

   initial begin
      int unsigned directed_keys;
      int unsigned target;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: unmapped codes at both ends, backspace on empty, then a full
      // password change from the reset code to one using the extreme digits
      send_key(5'd0);
      send_key(5'd3);
      send_key(5'd16);
      send_key(5'd31);
      send_key(KEY_BSP);
      send_key(key_for_digit(4'd9));
      send_key(KEY_BSP);
      send_key(KEY_CHG);
      send_code(32'h12345678, 1'b0);
      send_code(32'h90000009, 1'b0);
      directed_keys = keys_sent;

      // three phases: sender mostly busy, then receiver mostly busy, then no idling
      // with one long receiver hold-off so the block fills and pushes back
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 12;
               receiver_idle_pct = 69;
            end
            1: begin
               sender_idle_pct = 69;
               receiver_idle_pct = 12;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
               hold_request = 1'b1;
            end
         endcase
         target = directed_keys + (phase + 1) * RANDOM_KEYS / 3;
         while (keys_sent < target) run_sequence();
      end
      push <= 1'b0;

      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d keys sent, %0d result beats checked, input held back on %0d edges",
               keys_sent, sb.results_checked, stall_cycles);
      $display("outcomes: %0d unlock, %0d wrong, %0d old ok, %0d old rejected, %0d saved",
               sb.events_seen[EV_UNLOCK], sb.events_seen[EV_WRONG], sb.events_seen[EV_OLD_OK],
               sb.events_seen[EV_OLD_BAD], sb.events_seen[EV_SAVED]);
      if (sb.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
